@@ rtl/core/viterbi_log_domain_decoder_macros.svh @@
// assertion macros for the log-domain viterbi decoder
`ifndef VITERBI_LOG_DOMAIN_DECODER_MACROS_SVH
`define VITERBI_LOG_DOMAIN_DECODER_MACROS_SVH
`ifndef SYNTH
`define VLD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define VLD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);
`else
`define VLD_ASSERT(lbl, prop, msg)
`define VLD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/core/vld_pkg.sv @@
// shared constants, codes and saturation helpers of the viterbi decoder
package vld_pkg;

  localparam int MAX_STATES = 16;
  localparam int IDX_W      = 4;
  localparam int NS_W       = 5;
  localparam int MAX_LEN    = 64;
  localparam int T_W        = 6;
  localparam int STEP_W     = 7;
  localparam int LOG_W      = 32;
  localparam int SCORE_W    = 40;
  localparam int TOTAL_W    = 48;
  localparam int WIDE_W     = 49;

  localparam logic [2:0] CMD_LOAD_START = 3'd0;
  localparam logic [2:0] CMD_LOAD_TRANS = 3'd1;
  localparam logic [2:0] CMD_LOAD_EMIS  = 3'd2;
  localparam logic [2:0] CMD_CLOSE_STEP = 3'd3;
  localparam logic [2:0] CMD_FINISH     = 3'd4;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  localparam logic [1:0] REG_NUM_STATES = 2'd0;
  localparam logic [1:0] REG_LOG_FLOOR  = 2'd1;
  localparam logic [1:0] REG_SCALE_THR  = 2'd2;

  localparam logic [NS_W-1:0]         RST_NUM_STATES = 5'd16;
  localparam logic signed [LOG_W-1:0] RST_LOG_FLOOR  = -32'sd45298483;
  localparam logic signed [LOG_W-1:0] RST_SCALE_THR  = -32'sd65536000;

  localparam logic signed [WIDE_W-1:0] SCORE_MAX = 49'sd549755813887;
  localparam logic signed [WIDE_W-1:0] SCORE_MIN = -49'sd549755813888;
  localparam logic signed [WIDE_W-1:0] TOTAL_MAX = 49'sd140737488355327;
  localparam logic signed [WIDE_W-1:0] TOTAL_MIN = -49'sd140737488355328;

  function automatic logic signed [SCORE_W-1:0] sat_score(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] r;
    r = (v > SCORE_MAX) ? SCORE_MAX : ((v < SCORE_MIN) ? SCORE_MIN : v);
    return r[SCORE_W-1:0];
  endfunction

  function automatic logic signed [TOTAL_W-1:0] sat_total(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] r;
    r = (v > TOTAL_MAX) ? TOTAL_MAX : ((v < TOTAL_MIN) ? TOTAL_MIN : v);
    return r[TOTAL_W-1:0];
  endfunction

endpackage

@@ rtl/core/viterbi_log_domain_decoder.sv @@
// log-domain viterbi decoder: table loads, max-plus step sequencer, backtrack and path output
// close step: pair and emission phases (init at step 0), then scan, optional rescale and copy,
//   n active states, one add-compare per state pair on the shared unit
// finish: final maximum, backtrack, then one result per path entry while the receiver keeps up;
//   an error finish sends a single error result instead; not ready meanwhile
// reset: asynchronous, active low; clears state, step count, total and flags, config to defaults, not tables
`include "viterbi_log_domain_decoder_macros.svh"
module viterbi_log_domain_decoder (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // config write port
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_index_i,
  input  logic [vld_pkg::LOG_W-1:0] cfg_data_i,
  // input stream
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [39:0]               s_axis_tdata,  // row_index[3:0], col_index[7:4], log_value[39:8]
  input  logic [2:0]                s_axis_tuser,  // command[2:0]
  // result stream
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [55:0]               m_axis_tdata,  // time_index[5:0], path_state[9:6], log_prob[49:10], zero pad
  output logic [1:0]                m_axis_tuser,  // status[1:0]
  output logic                      m_axis_tlast
);
  import vld_pkg::*;

  // sequencer codes
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_INIT0  = 4'd1;
  localparam logic [3:0] S_PAIR   = 4'd2;
  localparam logic [3:0] S_EMIS   = 4'd3;
  localparam logic [3:0] S_SCAN   = 4'd4;
  localparam logic [3:0] S_SUB    = 4'd5;
  localparam logic [3:0] S_COPY   = 4'd6;
  localparam logic [3:0] S_BEST   = 4'd7;
  localparam logic [3:0] S_BT_RD  = 4'd8;
  localparam logic [3:0] S_BT_WR  = 4'd9;
  localparam logic [3:0] S_OUT_RD = 4'd10;
  localparam logic [3:0] S_OUT_LD = 4'd11;
  localparam logic [3:0] S_ERR    = 4'd12;

  // config registers
  logic [NS_W-1:0]         num_states_q;
  logic signed [LOG_W-1:0] log_floor_q, scale_thr_q;

  // tables and score rows
  logic signed [LOG_W-1:0]   start_q [MAX_STATES];
  logic signed [LOG_W-1:0]   emis_q  [MAX_STATES];
  logic signed [SCORE_W-1:0] prev_q  [MAX_STATES];
  logic signed [SCORE_W-1:0] cur_q   [MAX_STATES];

  // memories
  logic [LOG_W-1:0] trans_mem [MAX_STATES*MAX_STATES];
  logic [IDX_W-1:0] bp_mem    [MAX_LEN*MAX_STATES];
  logic [IDX_W-1:0] path_mem  [MAX_LEN];
  logic signed [LOG_W-1:0] trans_rd_q;
  logic [IDX_W-1:0]        bp_rd_q, path_rd_q;

  // sequencer state
  logic [3:0]                state_q, state_d;
  logic [NS_W-1:0]           j_q, j_d, i_q, i_d, k_q, k_d;
  logic                      pv_q, pv_d;
  logic [IDX_W-1:0]          pi_q, pi_d;
  logic signed [SCORE_W-1:0] best_q, best_d, mx_q, mx_d;
  logic [IDX_W-1:0]          arg_q, arg_d;
  logic                      low_q, low_d, first_q, first_d;
  logic [STEP_W-1:0]         step_q, step_d, len_q, len_d;
  logic signed [TOTAL_W-1:0] total_q, total_d;
  logic                      ovf_q, ovf_d;
  logic [T_W-1:0]            bt_t_q, bt_t_d, e_q, e_d;
  logic [IDX_W-1:0]          bt_s_q, bt_s_d;
  logic signed [SCORE_W-1:0] lp_q, lp_d;
  logic [1:0]                err_q, err_d;

  // output register
  logic                      ov_q, ov_d;
  logic [T_W-1:0]            o_time_q, o_time_d;
  logic [IDX_W-1:0]          o_path_q, o_path_d;
  logic signed [SCORE_W-1:0] o_lp_q, o_lp_d;
  logic [1:0]                o_stat_q, o_stat_d;
  logic                      o_last_q, o_last_d;

  // input fields
  logic [2:0]              in_cmd;
  logic [IDX_W-1:0]        in_row, in_col;
  logic signed [LOG_W-1:0] in_val, in_clamped;
  logic                    in_xfer, out_free;

  assign in_cmd     = s_axis_tuser;
  assign in_row     = s_axis_tdata[3:0];
  assign in_col     = s_axis_tdata[7:4];
  assign in_val     = s_axis_tdata[39:8];
  assign in_clamped = (in_val < log_floor_q) ? log_floor_q : in_val;
  assign in_xfer    = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  // output slot can take a new result when empty or being drained this cycle
  assign out_free   = !ov_q || m_axis_tready;

  // effective state count: zero acts as one, anything above the maximum is clipped
  logic [NS_W-1:0] n_eff, n_m1;
  always_comb begin
    if (num_states_q == '0) begin
      n_eff = NS_W'(1);
    end else if (num_states_q > NS_W'(MAX_STATES)) begin
      n_eff = NS_W'(MAX_STATES);
    end else begin
      n_eff = num_states_q;
    end
    n_m1 = n_eff - NS_W'(1);
  end

  // memory ports, driven by the sequencer
  logic                               trans_we;
  logic [2*IDX_W-1:0]                 trans_waddr, trans_raddr;
  logic                               bp_we;
  logic [T_W+IDX_W-1:0]               bp_waddr, bp_raddr;
  logic                               path_we;
  logic [T_W-1:0]                     path_waddr, path_raddr;
  logic [IDX_W-1:0]                   path_wdata;

  // shared add-compare unit datapath
  logic [IDX_W-1:0]          prev_idx;
  logic signed [SCORE_W-1:0] prev_sel, pair_sum, cur_sel, mx_new;
  logic                      low_new, rescale_go;

  assign prev_idx = (state_q == S_BEST) ? k_q[IDX_W-1:0] : pi_q;
  assign prev_sel = prev_q[prev_idx];
  assign cur_sel  = cur_q[k_q[IDX_W-1:0]];
  assign pair_sum = sat_score(WIDE_W'(prev_sel) + WIDE_W'(trans_rd_q));
  assign mx_new   = ((k_q == '0) || (cur_sel > mx_q)) ? cur_sel : mx_q;
  assign low_new  = ((k_q == '0) ? 1'b0 : low_q) | (cur_sel < SCORE_W'(scale_thr_q));
  // step 0 rescales only when the best entry is low, later steps when any entry is
  assign rescale_go = first_q ? (mx_new < SCORE_W'(scale_thr_q)) : low_new;

  // row-write requests for the score arrays
  logic                      cur_we;
  logic [IDX_W-1:0]          cur_widx;
  logic signed [SCORE_W-1:0] cur_wdata;
  logic                      copy_en;

  always_comb begin
    state_d  = state_q;
    j_d      = j_q;
    i_d      = i_q;
    k_d      = k_q;
    pv_d     = pv_q;
    pi_d     = pi_q;
    best_d   = best_q;
    arg_d    = arg_q;
    mx_d     = mx_q;
    low_d    = low_q;
    first_d  = first_q;
    step_d   = step_q;
    len_d    = len_q;
    total_d  = total_q;
    ovf_d    = ovf_q;
    bt_t_d   = bt_t_q;
    bt_s_d   = bt_s_q;
    e_d      = e_q;
    lp_d     = lp_q;
    err_d    = err_q;
    ov_d     = ov_q && !m_axis_tready;
    o_time_d = o_time_q;
    o_path_d = o_path_q;
    o_lp_d   = o_lp_q;
    o_stat_d = o_stat_q;
    o_last_d = o_last_q;

    trans_we    = 1'b0;
    trans_waddr = {in_row, in_col};
    trans_raddr = {i_q[IDX_W-1:0], j_q[IDX_W-1:0]};
    bp_we       = 1'b0;
    bp_waddr    = {step_q[T_W-1:0], j_q[IDX_W-1:0]};
    bp_raddr    = {bt_t_q, bt_s_q};
    path_we     = 1'b0;
    path_waddr  = bt_t_q - T_W'(1);
    path_wdata  = bp_rd_q;
    path_raddr  = e_q;
    cur_we      = 1'b0;
    cur_widx    = j_q[IDX_W-1:0];
    cur_wdata   = '0;
    copy_en     = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          case (in_cmd)
            CMD_LOAD_TRANS: trans_we = 1'b1;
            CMD_CLOSE_STEP: begin
              j_d  = '0;
              i_d  = '0;
              pv_d = 1'b0;
              if (step_q == STEP_W'(MAX_LEN)) begin
                ovf_d = 1'b1;
              end else if (step_q == '0) begin
                state_d = S_INIT0;
              end else begin
                state_d = S_PAIR;
              end
            end
            CMD_FINISH: begin
              k_d = '0;
              if (ovf_q) begin
                err_d   = STATUS_OVERFLOW;
                state_d = S_ERR;
              end else if (step_q == '0) begin
                err_d   = STATUS_EMPTY;
                state_d = S_ERR;
              end else begin
                state_d = S_BEST;
              end
            end
            default: ;
          endcase
        end
      end
      S_INIT0: begin
        cur_we    = 1'b1;
        cur_wdata = sat_score(WIDE_W'(start_q[j_q[IDX_W-1:0]]) +
                              WIDE_W'(emis_q[j_q[IDX_W-1:0]]));
        j_d = j_q + NS_W'(1);
        if (j_q == n_m1) begin
          k_d     = '0;
          first_d = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_PAIR: begin
        // issue the next transition read while the previous one is combined
        if (i_q < n_eff) begin
          i_d  = i_q + NS_W'(1);
          pv_d = 1'b1;
          pi_d = i_q[IDX_W-1:0];
        end else begin
          pv_d = 1'b0;
        end
        if (pv_q) begin
          if ((pi_q == '0) || (pair_sum > best_q)) begin
            best_d = pair_sum;
            arg_d  = pi_q;
          end
          if ({1'b0, pi_q} == n_m1) begin
            state_d = S_EMIS;
          end
        end
      end
      S_EMIS: begin
        cur_we    = 1'b1;
        cur_wdata = sat_score(WIDE_W'(best_q) + WIDE_W'(emis_q[j_q[IDX_W-1:0]]));
        bp_we     = 1'b1;
        i_d       = '0;
        pv_d      = 1'b0;
        if (j_q == n_m1) begin
          k_d     = '0;
          first_d = 1'b0;
          state_d = S_SCAN;
        end else begin
          j_d     = j_q + NS_W'(1);
          state_d = S_PAIR;
        end
      end
      S_SCAN: begin
        mx_d  = mx_new;
        low_d = low_new;
        k_d   = k_q + NS_W'(1);
        if (k_q == n_m1) begin
          k_d = '0;
          if (rescale_go) begin
            total_d = sat_total(WIDE_W'(total_q) + WIDE_W'(mx_new));
            state_d = S_SUB;
          end else begin
            state_d = S_COPY;
          end
        end
      end
      S_SUB: begin
        cur_we    = 1'b1;
        cur_widx  = k_q[IDX_W-1:0];
        cur_wdata = sat_score(WIDE_W'(cur_sel) - WIDE_W'(mx_q));
        k_d       = k_q + NS_W'(1);
        if (k_q == n_m1) begin
          state_d = S_COPY;
        end
      end
      S_COPY: begin
        copy_en = 1'b1;
        step_d  = step_q + STEP_W'(1);
        state_d = S_IDLE;
      end
      S_BEST: begin
        if ((k_q == '0) || (prev_sel > best_q)) begin
          best_d = prev_sel;
          arg_d  = k_q[IDX_W-1:0];
        end
        k_d = k_q + NS_W'(1);
        if (k_q == n_m1) begin
          lp_d       = sat_score(WIDE_W'(best_d) + WIDE_W'(total_q));
          len_d      = step_q;
          bt_t_d     = T_W'(step_q - STEP_W'(1));
          bt_s_d     = arg_d;
          path_we    = 1'b1;
          path_waddr = T_W'(step_q - STEP_W'(1));
          path_wdata = arg_d;
          step_d     = '0;
          total_d    = '0;
          ovf_d      = 1'b0;
          e_d        = '0;
          state_d    = (step_q == STEP_W'(1)) ? S_OUT_RD : S_BT_RD;
        end
      end
      S_BT_RD: state_d = S_BT_WR;
      S_BT_WR: begin
        path_we = 1'b1;
        bt_s_d  = bp_rd_q;
        bt_t_d  = bt_t_q - T_W'(1);
        state_d = (bt_t_q == T_W'(1)) ? S_OUT_RD : S_BT_RD;
      end
      S_OUT_RD: state_d = S_OUT_LD;
      S_OUT_LD: begin
        if (out_free) begin
          ov_d     = 1'b1;
          o_time_d = e_q;
          o_path_d = path_rd_q;
          o_lp_d   = lp_q;
          o_stat_d = STATUS_OK;
          o_last_d = ({1'b0, e_q} + STEP_W'(1)) == len_q;
          if (o_last_d) begin
            state_d = S_IDLE;
          end else begin
            e_d     = e_q + T_W'(1);
            state_d = S_OUT_RD;
          end
        end
      end
      S_ERR: begin
        if (out_free) begin
          ov_d     = 1'b1;
          o_time_d = '0;
          o_path_d = '0;
          o_lp_d   = '0;
          o_stat_d = err_q;
          o_last_d = 1'b1;
          step_d   = '0;
          total_d  = '0;
          ovf_d    = 1'b0;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      step_q       <= '0;
      total_q      <= '0;
      ovf_q        <= 1'b0;
      ov_q         <= 1'b0;
      pv_q         <= 1'b0;
      num_states_q <= RST_NUM_STATES;
      log_floor_q  <= RST_LOG_FLOOR;
      scale_thr_q  <= RST_SCALE_THR;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      total_q <= total_d;
      ovf_q   <= ovf_d;
      ov_q    <= ov_d;
      pv_q    <= pv_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_NUM_STATES: num_states_q <= cfg_data_i[NS_W-1:0];
          REG_LOG_FLOOR:  log_floor_q  <= cfg_data_i;
          REG_SCALE_THR:  scale_thr_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk_i) begin
    j_q      <= j_d;
    i_q      <= i_d;
    k_q      <= k_d;
    pi_q     <= pi_d;
    best_q   <= best_d;
    arg_q    <= arg_d;
    mx_q     <= mx_d;
    low_q    <= low_d;
    first_q  <= first_d;
    len_q    <= len_d;
    bt_t_q   <= bt_t_d;
    bt_s_q   <= bt_s_d;
    e_q      <= e_d;
    lp_q     <= lp_d;
    err_q    <= err_d;
    o_time_q <= o_time_d;
    o_path_q <= o_path_d;
    o_lp_q   <= o_lp_d;
    o_stat_q <= o_stat_d;
    o_last_q <= o_last_d;
    if (in_xfer && (in_cmd == CMD_LOAD_START)) begin
      start_q[in_row] <= in_clamped;
    end
    if (in_xfer && (in_cmd == CMD_LOAD_EMIS)) begin
      emis_q[in_row] <= in_clamped;
    end
    if (cur_we) begin
      cur_q[cur_widx] <= cur_wdata;
    end
    // whole row handed over at the end of a step
    if (copy_en) begin
      for (int s = 0; s < MAX_STATES; s++) begin
        prev_q[s] <= cur_q[s];
      end
    end
  end

  // transition, backpointer and path memories
  always_ff @(posedge clk_i) begin
    if (trans_we) begin
      trans_mem[trans_waddr] <= in_clamped;
    end
    trans_rd_q <= trans_mem[trans_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (bp_we) begin
      bp_mem[bp_waddr] <= arg_q;
    end
    bp_rd_q <= bp_mem[bp_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (path_we) begin
      path_mem[path_waddr] <= path_wdata;
    end
    path_rd_q <= path_mem[path_raddr];
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {6'd0, o_lp_q, o_path_q, o_time_q};
  assign m_axis_tuser  = o_stat_q;
  assign m_axis_tlast  = o_last_q;

  // error results are single and carry no path
  `VLD_ASSERT(a_err_single, (m_axis_tvalid && (m_axis_tuser != STATUS_OK)) |-> (m_axis_tlast && (o_path_q == '0)), "error result not final")
  // the step counter never passes the sequence limit
  `VLD_ASSERT(a_step_bound, step_q <= STEP_W'(MAX_LEN), "step count beyond limit")
  // overflow only happens with a full sequence
  `VLD_ASSERT(a_ovf_full, ovf_q |-> (step_q == STEP_W'(MAX_LEN)), "overflow without full sequence")
  // overflow is only cleared by the error result
  `VLD_ASSERT_NEXT(a_ovf_sticky, ovf_q && (state_q != S_ERR), ovf_q, "overflow lost")

endmodule
